/* rtl/blpg_pkg.sv */
// Shared types, widths and codes for the Bresenham line pixel generator.
`timescale 1ns / 1ps

package blpg_pkg;

    // Coordinate width; the rest of the datapath widths follow from it.
    localparam int COORD_BITS = 12;

    // Fixed field widths of registers and result fields.
    localparam int WIN_W      = 11;
    localparam int STRIDE_W   = 14;
    localparam int PB_W       = 4;
    localparam int OFF_W      = 27;
    localparam int COLOR_W    = 32;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 14;

    // Error term carries 2*err without overflow. The error term itself can
    // reach about 1.5 times the larger delta, so its double needs three bits
    // above the coordinate width.
    localparam int ERR_W = COORD_BITS + 3;
    // Width used for the window compare.
    localparam int CMP_W = (COORD_BITS > WIN_W) ? COORD_BITS : WIN_W;
    // Offset products and their sum.
    localparam int PY_W  = COORD_BITS + STRIDE_W;
    localparam int PX_W  = COORD_BITS + PB_W;
    localparam int SUM_W = ((PY_W + 1) > OFF_W) ? (PY_W + 1) : OFF_W;

    // Register reset values.
    localparam logic [WIN_W-1:0]    RST_WIDTH       = WIN_W'(800);
    localparam logic [WIN_W-1:0]    RST_HEIGHT      = WIN_W'(600);
    localparam logic [STRIDE_W-1:0] RST_STRIDE      = STRIDE_W'(3200);
    localparam logic [PB_W-1:0]     RST_PIXEL_BYTES = PB_W'(4);

    // Stream payload layout, lowest field first.
    localparam int IN_RAW_W     = 4 * COORD_BITS + COLOR_W;
    localparam int IN_TDATA_W   = ((IN_RAW_W + 7) / 8) * 8;
    localparam int IN_SX_LSB    = 0;
    localparam int IN_SY_LSB    = COORD_BITS;
    localparam int IN_EX_LSB    = 2 * COORD_BITS;
    localparam int IN_EY_LSB    = 3 * COORD_BITS;
    localparam int IN_COLOR_LSB = 4 * COORD_BITS;

    localparam int OUT_RAW_W     = 2 * COORD_BITS + OFF_W + COLOR_W;
    localparam int OUT_TDATA_W   = ((OUT_RAW_W + 7) / 8) * 8;
    localparam int OUT_Y_LSB     = COORD_BITS;
    localparam int OUT_OFF_LSB   = 2 * COORD_BITS;
    localparam int OUT_COLOR_LSB = 2 * COORD_BITS + OFF_W;

    // Command codes carried in the input tuser.
    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_STEP = 1'b1
    } t_opcode;

    // Configuration register indexes.
    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_WIDTH       = 2'd0,
        CFG_HEIGHT      = 2'd1,
        CFG_STRIDE      = 2'd2,
        CFG_PIXEL_BYTES = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [WIN_W-1:0]    width;
        logic [WIN_W-1:0]    height;
        logic [STRIDE_W-1:0] stride;
        logic [PB_W-1:0]     pixel_bytes;
    } t_cfg;

    // Walk state of the active line.
    typedef struct packed {
        logic signed [COORD_BITS-1:0] cur_x;
        logic signed [COORD_BITS-1:0] cur_y;
        logic signed [COORD_BITS-1:0] tgt_x;
        logic signed [COORD_BITS-1:0] tgt_y;
        logic [COORD_BITS-1:0]        abs_dx;
        logic [COORD_BITS-1:0]        abs_dy;
        logic                         x_neg;
        logic                         y_neg;
        logic signed [ERR_W-1:0]      err;
        logic [COLOR_W-1:0]           color;
    } t_line;

    // Line endpoints as they arrive with a load beat.
    typedef struct packed {
        logic signed [COORD_BITS-1:0] sx;
        logic signed [COORD_BITS-1:0] sy;
        logic signed [COORD_BITS-1:0] ex;
        logic signed [COORD_BITS-1:0] ey;
        logic [COLOR_W-1:0]           color;
    } t_load;

    // One produced pixel.
    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic                         in_win;
        logic [OFF_W-1:0]             offset;
        logic [COLOR_W-1:0]           color;
        logic                         last;
    } t_pixel;

endpackage

/* rtl/bresenham_line_pixel_generator.sv */
// Top level of the Bresenham line pixel generator.
// A load beat (tuser = 0) sets up a line and yields no output; each step beat
// (tuser = 1) while a line is active yields one pixel, registered in the output
// register (or the skid slot on a stall), and advances the position. One beat
// is taken every clock while ready is high: the line state is updated in the
// accepting cycle by a single pass through the setup, window, offset multiply
// and error-rule logic. Input ready drops only while two pixels wait downstream
// (output register plus skid slot full). Steps with no active line are absorbed
// silently, and the pixel at the end point carries tlast and ends the line.
`timescale 1ns / 1ps

module bresenham_line_pixel_generator
    import blpg_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Configuration writes.
    input  logic                   i_cfg_we,
    input  logic [CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0]  i_cfg_wdata,
    // Command stream.
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // tdata: start_x, start_y, end_x, end_y, pixel_color
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    // tuser: opcode
    input  logic                   i_s_axis_tuser,
    // Pixel stream.
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // tdata: pix_x, pix_y, byte_offset, pix_color, zero pad
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    // tuser: inside_window
    output logic                   o_m_axis_tuser,
    // tlast: last_pixel
    output logic                   o_m_axis_tlast
);

    t_cfg   r_cfg;
    t_line  r_line, n_line;
    logic   r_busy, n_busy;
    t_load  load;
    t_line  setup, adv;
    t_pixel pix, out_pix;
    logic   accept, is_load, push;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.width       <= RST_WIDTH;
            r_cfg.height      <= RST_HEIGHT;
            r_cfg.stride      <= RST_STRIDE;
            r_cfg.pixel_bytes <= RST_PIXEL_BYTES;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_addr))
                CFG_WIDTH:       r_cfg.width       <= i_cfg_wdata[WIN_W-1:0];
                CFG_HEIGHT:      r_cfg.height      <= i_cfg_wdata[WIN_W-1:0];
                CFG_STRIDE:      r_cfg.stride      <= i_cfg_wdata[STRIDE_W-1:0];
                CFG_PIXEL_BYTES: r_cfg.pixel_bytes <= i_cfg_wdata[PB_W-1:0];
                default: ;
            endcase
        end
    end

    // Unpack the command beat.
    always_comb begin
        load.sx    = i_s_axis_tdata[IN_SX_LSB +: COORD_BITS];
        load.sy    = i_s_axis_tdata[IN_SY_LSB +: COORD_BITS];
        load.ex    = i_s_axis_tdata[IN_EX_LSB +: COORD_BITS];
        load.ey    = i_s_axis_tdata[IN_EY_LSB +: COORD_BITS];
        load.color = i_s_axis_tdata[IN_COLOR_LSB +: COLOR_W];
    end

    blpg_step u_step (
        .i_line  (r_line),
        .i_cfg   (r_cfg),
        .i_load  (load),
        .o_setup (setup),
        .o_pix   (pix),
        .o_adv   (adv)
    );

    assign accept  = i_s_axis_tvalid && o_s_axis_tready;
    assign is_load = t_opcode'(i_s_axis_tuser) == OP_LOAD;
    assign push    = accept && !is_load && r_busy;

    // Next line state: load restarts, a step advances or ends the line.
    always_comb begin
        n_line = r_line;
        n_busy = r_busy;
        if (accept && is_load) begin
            n_line = setup;
            n_busy = 1'b1;
        end else if (push) begin
            if (pix.last) begin
                n_busy = 1'b0;
            end else begin
                n_line = adv;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line <= '0;
            r_busy <= 1'b0;
        end else begin
            r_line <= n_line;
            r_busy <= n_busy;
        end
    end

    blpg_out_buf u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pix   (pix),
        .o_ready (o_s_axis_tready),
        .o_valid (o_m_axis_tvalid),
        .o_pix   (out_pix),
        .i_ready (i_m_axis_tready)
    );

    // Pack the pixel beat.
    assign o_m_axis_tdata = OUT_TDATA_W'({out_pix.color, out_pix.offset,
                                          out_pix.y, out_pix.x});
    assign o_m_axis_tuser = out_pix.in_win;
    assign o_m_axis_tlast = out_pix.last;

endmodule

/* rtl/blpg_step.sv */
// Line setup, pixel evaluation and one Bresenham advance, all combinational.
`timescale 1ns / 1ps

module blpg_step
    import blpg_pkg::*;
(
    input  t_line  i_line,
    input  t_cfg   i_cfg,
    input  t_load  i_load,
    output t_line  o_setup,
    output t_pixel o_pix,
    output t_line  o_adv
);

    localparam logic signed [COORD_BITS-1:0] C_PLUS  = COORD_BITS'(1);
    localparam logic signed [COORD_BITS-1:0] C_MINUS = {COORD_BITS{1'b1}};

    logic signed [COORD_BITS:0]   sx_e, sy_e, ex_e, ey_e;
    logic                         x_lt, y_lt;
    logic [COORD_BITS:0]          dx_full, dy_full;
    logic signed [ERR_W-1:0]      dx_s, dy_s, e2, ld_dx_s, ld_dy_s;
    logic                         step_x, step_y;
    logic                         x_in, y_in, in_win;
    logic [CMP_W-1:0]             x_cmp, y_cmp, w_cmp, h_cmp;
    logic [PY_W-1:0]              prod_y;
    logic [PX_W-1:0]              prod_x;
    logic [SUM_W-1:0]             off_sum;

    // Load setup: absolute deltas, step signs and the starting error term.
    always_comb begin
        sx_e    = (COORD_BITS+1)'(i_load.sx);
        sy_e    = (COORD_BITS+1)'(i_load.sy);
        ex_e    = (COORD_BITS+1)'(i_load.ex);
        ey_e    = (COORD_BITS+1)'(i_load.ey);
        x_lt    = sx_e < ex_e;
        y_lt    = sy_e < ey_e;
        dx_full = x_lt ? (COORD_BITS+1)'(ex_e - sx_e) : (COORD_BITS+1)'(sx_e - ex_e);
        dy_full = y_lt ? (COORD_BITS+1)'(ey_e - sy_e) : (COORD_BITS+1)'(sy_e - ey_e);
        ld_dx_s = signed'(ERR_W'(dx_full[COORD_BITS-1:0]));
        ld_dy_s = signed'(ERR_W'(dy_full[COORD_BITS-1:0]));

        o_setup.cur_x  = i_load.sx;
        o_setup.cur_y  = i_load.sy;
        o_setup.tgt_x  = i_load.ex;
        o_setup.tgt_y  = i_load.ey;
        o_setup.abs_dx = dx_full[COORD_BITS-1:0];
        o_setup.abs_dy = dy_full[COORD_BITS-1:0];
        o_setup.x_neg  = !x_lt;
        o_setup.y_neg  = !y_lt;
        o_setup.err    = ld_dx_s - ld_dy_s;
        o_setup.color  = i_load.color;
    end

    // Window test on the current position.
    always_comb begin
        x_cmp  = CMP_W'(unsigned'(i_line.cur_x));
        y_cmp  = CMP_W'(unsigned'(i_line.cur_y));
        w_cmp  = CMP_W'(i_cfg.width);
        h_cmp  = CMP_W'(i_cfg.height);
        x_in   = !i_line.cur_x[COORD_BITS-1] && (x_cmp < w_cmp);
        y_in   = !i_line.cur_y[COORD_BITS-1] && (y_cmp < h_cmp);
        in_win = x_in && y_in;
    end

    // Framebuffer byte offset, forced to zero outside the window.
    always_comb begin
        prod_y  = PY_W'(unsigned'(i_line.cur_y)) * PY_W'(i_cfg.stride);
        prod_x  = PX_W'(unsigned'(i_line.cur_x)) * PX_W'(i_cfg.pixel_bytes);
        off_sum = SUM_W'(prod_y) + SUM_W'(prod_x);
    end

    always_comb begin
        o_pix.x      = i_line.cur_x;
        o_pix.y      = i_line.cur_y;
        o_pix.in_win = in_win;
        o_pix.offset = in_win ? off_sum[OFF_W-1:0] : '0;
        o_pix.color  = i_line.color;
        o_pix.last   = (i_line.cur_x == i_line.tgt_x) && (i_line.cur_y == i_line.tgt_y);
    end

    // Bresenham advance: e2 = 2*err decides which axes move.
    always_comb begin
        dx_s   = signed'(ERR_W'(i_line.abs_dx));
        dy_s   = signed'(ERR_W'(i_line.abs_dy));
        e2     = i_line.err <<< 1;
        step_x = e2 > -dy_s;
        step_y = e2 < dx_s;

        o_adv       = i_line;
        o_adv.err   = i_line.err - (step_x ? dy_s : '0) + (step_y ? dx_s : '0);
        if (step_x) begin
            o_adv.cur_x = i_line.cur_x + (i_line.x_neg ? C_MINUS : C_PLUS);
        end
        if (step_y) begin
            o_adv.cur_y = i_line.cur_y + (i_line.y_neg ? C_MINUS : C_PLUS);
        end
    end

endmodule

/* rtl/blpg_out_buf.sv */
// Two-entry output register with skid slot for produced pixels.
`timescale 1ns / 1ps

module blpg_out_buf
    import blpg_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_pixel i_pix,
    output logic   o_ready,
    output logic   o_valid,
    output t_pixel o_pix,
    input  logic   i_ready
);

    logic   r_out_valid, r_skid_valid;
    t_pixel r_out, r_skid;

    // Upstream may push as long as the skid slot is free.
    assign o_ready = !r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_pix   = r_out;

    // Control: the output register refills from the skid slot first.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || i_ready) begin
            r_out_valid  <= r_skid_valid || i_push;
            r_skid_valid <= 1'b0;
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    // Payload.
    always_ff @(posedge i_clk) begin
        if (!r_out_valid || i_ready) begin
            r_out <= r_skid_valid ? r_skid : i_pix;
        end else if (i_push) begin
            r_skid <= i_pix;
        end
    end

endmodule

/* rtl/blpg_checker.sv */
// Port-level checks for the Bresenham line pixel generator, bound to the top.
`timescale 1ns / 1ps

module blpg_checker
    import blpg_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   o_s_axis_tready,
    input logic                   o_m_axis_tvalid,
    input logic                   i_m_axis_tready,
    input logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    input logic                   o_m_axis_tuser,
    input logic                   o_m_axis_tlast
);

    // Reset empties the output side and opens the input.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid && o_s_axis_tready)
        else $error("output not empty or input not ready after reset");

    // A stalled pixel beat stays put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
        o_m_axis_tvalid && $stable(o_m_axis_tdata) &&
        $stable(o_m_axis_tuser) && $stable(o_m_axis_tlast))
        else $error("stalled pixel beat changed");

    // Input backpressure only comes from a pixel held by downstream.
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> $past(o_m_axis_tvalid && !i_m_axis_tready))
        else $error("input stalled without a waiting pixel");

    // A pixel inside the window has non-negative coordinates.
    a_inside_coords: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser |->
        !o_m_axis_tdata[COORD_BITS-1] && !o_m_axis_tdata[OUT_Y_LSB+COORD_BITS-1])
        else $error("inside pixel with negative coordinate");

    // A pixel outside the window carries a zero offset.
    a_outside_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser |->
        o_m_axis_tdata[OUT_OFF_LSB +: OFF_W] == '0)
        else $error("outside pixel with nonzero offset");

endmodule

bind bresenham_line_pixel_generator blpg_checker u_blpg_checker (.*);

/* verif/tb_bresenham_line_pixel_generator.sv */
// Self-checking stream testbench for the Bresenham line pixel generator.
`timescale 1ns / 1ps

module tb_bresenham_line_pixel_generator;
    import blpg_pkg::*;

    // Tracks the line walk, predicts every pixel beat and checks the output stream.
    class line_walk_scoreboard;
        t_cfg               regs;
        int                 pos_x, pos_y, end_x, end_y;
        int                 dist_x, dist_y, err;
        bit                 neg_x, neg_y, active;
        logic [COLOR_W-1:0] color;
        t_pixel             expected_pixels[$];
        int                 mismatches, lines_loaded, pixels_checked;
        int                 pixels_inside, line_ends;

        function new();
            regs.width       = RST_WIDTH;
            regs.height      = RST_HEIGHT;
            regs.stride      = RST_STRIDE;
            regs.pixel_bytes = RST_PIXEL_BYTES;
            color            = '0;
        endfunction

        // Mirror a register write.
        function void write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_WIDTH:       regs.width       = val[WIN_W-1:0];
                CFG_HEIGHT:      regs.height      = val[WIN_W-1:0];
                CFG_STRIDE:      regs.stride      = val[STRIDE_W-1:0];
                CFG_PIXEL_BYTES: regs.pixel_bytes = val[PB_W-1:0];
                default: ;
            endcase
        endfunction

        // Apply one accepted command beat; a step on an active line queues a pixel.
        function void note_beat(t_opcode op, t_load ld);
            t_pixel px;
            int     e2, w, h;
            if (op == OP_LOAD) begin
                pos_x  = ld.sx;
                pos_y  = ld.sy;
                end_x  = ld.ex;
                end_y  = ld.ey;
                color  = ld.color;
                neg_x  = !(pos_x < end_x);
                neg_y  = !(pos_y < end_y);
                dist_x = (end_x > pos_x) ? end_x - pos_x : pos_x - end_x;
                dist_y = (end_y > pos_y) ? end_y - pos_y : pos_y - end_y;
                err    = dist_x - dist_y;
                active = 1'b1;
                lines_loaded++;
                return;
            end
            // A step with no line in progress is dropped.
            if (!active) return;

            w         = regs.width;
            h         = regs.height;
            px.x      = COORD_BITS'(pos_x);
            px.y      = COORD_BITS'(pos_y);
            px.in_win = (pos_x >= 0) && (pos_y >= 0) && (pos_x < w) && (pos_y < h);
            px.offset = px.in_win ? OFF_W'(longint'(pos_y) * regs.stride +
                                           longint'(pos_x) * regs.pixel_bytes) : '0;
            px.color  = color;
            px.last   = (pos_x == end_x) && (pos_y == end_y);
            expected_pixels.push_back(px);

            // Advance by the error rule, both tests against the same doubled error.
            if (px.last) begin
                active = 1'b0;
            end else begin
                e2 = 2 * err;
                if (e2 > -dist_y) begin
                    err   -= dist_y;
                    pos_x += neg_x ? -1 : 1;
                end
                if (e2 < dist_x) begin
                    err   += dist_x;
                    pos_y += neg_y ? -1 : 1;
                end
            end
        endfunction

        function void compare_field(string name, logic signed [63:0] want,
                                    logic signed [63:0] got);
            if (got !== want) begin
                $error("%s mismatch: expected %0d, actual %0d", name, want, got);
                mismatches++;
            end
        endfunction

        // Compare one accepted pixel beat with the oldest prediction.
        function void check_pixel(t_pixel got);
            t_pixel want;
            if (expected_pixels.size() == 0) begin
                $error("pixel beat with nothing pending: x=%0d y=%0d", got.x, got.y);
                mismatches++;
                return;
            end
            want = expected_pixels.pop_front();
            compare_field("pix_x", want.x, got.x);
            compare_field("pix_y", want.y, got.y);
            compare_field("inside_window", want.in_win, got.in_win);
            compare_field("byte_offset", want.offset, got.offset);
            compare_field("pix_color", want.color, got.color);
            compare_field("last_pixel", want.last, got.last);
            pixels_checked++;
            if (want.in_win) pixels_inside++;
            if (want.last) line_ends++;
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [CFG_ADDR_W-1:0]  i_cfg_addr;
    logic [CFG_DATA_W-1:0]  i_cfg_wdata;
    logic                   i_s_axis_tvalid;
    logic                   o_s_axis_tready;
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata;
    logic                   i_s_axis_tuser;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;
    logic                   o_m_axis_tuser;
    logic                   o_m_axis_tlast;

    line_walk_scoreboard sb;
    int                  burst_left;

    bresenham_line_pixel_generator u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Watchdog for a hung run.
    initial begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // The pixel sink stalls in randomly chosen modes: always ready, ready half the time, or rarely ready.
    initial begin : sink_stall
        int mode, left;
        i_m_axis_tready = 1'b0;
        mode = 0;
        left = 0;
        forever begin
            @(negedge i_clk);
            if (left == 0) begin
                mode = $urandom_range(0, 2);
                left = $urandom_range(20, 120);
            end
            left--;
            case (mode)
                0:       i_m_axis_tready <= 1'b1;
                1:       i_m_axis_tready <= ($urandom_range(0, 1) == 1);
                default: i_m_axis_tready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    // Both handshakes are observed at the rising edge.
    always @(posedge i_clk) begin : beat_monitor
        t_pixel got;
        t_load  ld;
        if (i_rst_n) begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got.x      = o_m_axis_tdata[0 +: COORD_BITS];
                got.y      = o_m_axis_tdata[OUT_Y_LSB +: COORD_BITS];
                got.offset = o_m_axis_tdata[OUT_OFF_LSB +: OFF_W];
                got.color  = o_m_axis_tdata[OUT_COLOR_LSB +: COLOR_W];
                got.in_win = o_m_axis_tuser;
                got.last   = o_m_axis_tlast;
                sb.check_pixel(got);
            end
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                ld.sx    = i_s_axis_tdata[IN_SX_LSB +: COORD_BITS];
                ld.sy    = i_s_axis_tdata[IN_SY_LSB +: COORD_BITS];
                ld.ex    = i_s_axis_tdata[IN_EX_LSB +: COORD_BITS];
                ld.ey    = i_s_axis_tdata[IN_EY_LSB +: COORD_BITS];
                ld.color = i_s_axis_tdata[IN_COLOR_LSB +: COLOR_W];
                sb.note_beat(t_opcode'(i_s_axis_tuser), ld);
            end
        end
    end

    function automatic int clamp_coord(int v);
        if (v < -2048) return -2048;
        if (v > 2047) return 2047;
        return v;
    endfunction

    function automatic t_load make_load(int sx, int sy, int ex, int ey,
                                        logic [COLOR_W-1:0] c);
        t_load ld;
        ld.sx    = COORD_BITS'(sx);
        ld.sy    = COORD_BITS'(sy);
        ld.ex    = COORD_BITS'(ex);
        ld.ey    = COORD_BITS'(ey);
        ld.color = c;
        return ld;
    endfunction

    // Offer one command beat; the sender runs in bursts with idle gaps between.
    task automatic send_beat(t_opcode op, t_load ld);
        logic [IN_TDATA_W-1:0] td;
        td = '0;
        td[IN_SX_LSB +: COORD_BITS]  = ld.sx;
        td[IN_SY_LSB +: COORD_BITS]  = ld.sy;
        td[IN_EX_LSB +: COORD_BITS]  = ld.ex;
        td[IN_EY_LSB +: COORD_BITS]  = ld.ey;
        td[IN_COLOR_LSB +: COLOR_W]  = ld.color;
        if (burst_left == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= td;
        i_s_axis_tuser  <= op;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Step beats carry random payload, which the block must ignore.
    task automatic send_steps(int n);
        logic [95:0] r;
        repeat (n) begin
            r = {$urandom, $urandom, $urandom};
            send_beat(OP_STEP, r[79:0]);
        end
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
        sb.write_reg(idx, val);
    endtask

    // Random lines: mostly complete walks, some cut short by a new load, some noise.
    task automatic random_lines(int budget);
        int sent, sx, sy, ex, ey, span, pixels, steps, kind;
        sent = 0;
        while (sent < budget) begin
            span = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 150)
                                               : $urandom_range(0, 12);
            if ($urandom_range(0, 1) == 1) begin
                sx = $urandom_range(0, sb.regs.width + 8) - 4;
                sy = $urandom_range(0, sb.regs.height + 8) - 4;
            end else begin
                sx = $urandom_range(0, 4095) - 2048;
                sy = $urandom_range(0, 4095) - 2048;
            end
            sx = clamp_coord(sx);
            sy = clamp_coord(sy);
            ex = clamp_coord(sx + int'($urandom_range(0, 2 * span)) - span);
            ey = clamp_coord(sy + int'($urandom_range(0, 2 * span)) - span);
            pixels = ((ex > sx) ? ex - sx : sx - ex);
            if (((ey > sy) ? ey - sy : sy - ey) > pixels)
                pixels = (ey > sy) ? ey - sy : sy - ey;
            pixels++;
            kind = $urandom_range(0, 19);
            if (kind < 16) begin
                steps = pixels + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0);
            end else if (kind < 19) begin
                steps = $urandom_range(0, pixels - 1);
            end else begin
                steps = $urandom_range(0, 2 * pixels);
            end
            send_beat(OP_LOAD, make_load(sx, sy, ex, ey, $urandom));
            send_steps(steps);
            sent += 1 + ((steps < pixels) ? steps : pixels);
        end
    endtask

    // Let the block go idle, reprogram every register, then run random lines.
    task automatic run_phase(int w, int h, int stride, int pb, int budget);
        i_s_axis_tvalid <= 1'b0;
        while (sb.expected_pixels.size() != 0) @(posedge i_clk);
        repeat (4) @(negedge i_clk);
        write_reg(CFG_WIDTH, CFG_DATA_W'(w));
        write_reg(CFG_HEIGHT, CFG_DATA_W'(h));
        write_reg(CFG_STRIDE, CFG_DATA_W'(stride));
        write_reg(CFG_PIXEL_BYTES, CFG_DATA_W'(pb));
        random_lines(budget);
    endtask

    // Main sequence.
    initial begin
        sb              = new();
        burst_left      = 0;
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_addr      = '0;
        i_cfg_wdata     = '0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = OP_LOAD;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part at the reset register values.
        send_steps(1);                                            // no line yet
        send_beat(OP_LOAD, make_load(3, 4, 3, 4, 32'h0000_0000)); // single point
        send_steps(2);                                            // second step ignored
        send_beat(OP_LOAD, make_load(-2048, -2048, -2047, -2046, 32'hFFFF_FFFF));
        send_steps(3);
        send_beat(OP_LOAD, make_load(2047, 2047, 2045, 2046, 32'hA5A5_5A5A));
        send_steps(1);
        // Reload in the middle of a line.
        send_beat(OP_LOAD, make_load(0, 0, 2, -1, 32'h1234_5678));
        send_steps(3);
        // Crosses the bottom right corner of the default window.
        send_beat(OP_LOAD, make_load(799, 599, 800, 600, 32'h0F0F_F0F0));
        send_steps(2);
        // Vertical line, no movement in x.
        send_beat(OP_LOAD, make_load(5, 0, 5, 3, 32'h8000_0001));
        send_steps(4);

        // Register settings, extremes first.
        run_phase(2047, 2047, 16383, 15, 150);
        run_phase(1, 1, 0, 1, 150);
        run_phase(0, 0, 1, 0, 150);
        run_phase(800, 600, 3200, 4, 150);
        run_phase($urandom_range(1, 2047), $urandom_range(1, 2047),
                  $urandom_range(0, 16383), $urandom_range(1, 8), 150);
        run_phase($urandom_range(1, 64), $urandom_range(1, 64),
                  $urandom_range(0, 16383), $urandom_range(0, 15), 150);

        // Drain the pixel stream.
        i_s_axis_tvalid <= 1'b0;
        while (sb.expected_pixels.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("Walked %0d line loads over seven register settings; %0d pixels checked,",
                 sb.lines_loaded, sb.pixels_checked);
        $display("%0d of them inside the window and %0d marking a line end.",
                 sb.pixels_inside, sb.line_ends);
        if (sb.mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/blpg_pkg.sv
rtl/blpg_step.sv
rtl/blpg_out_buf.sv
rtl/bresenham_line_pixel_generator.sv
rtl/blpg_checker.sv
verif/tb_bresenham_line_pixel_generator.sv
